FILE: design/signal_pending_mask_dispatcher_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signal pending mask dispatcher
// Concurrent check wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_PENDING_MASK_DISPATCHER_MACROS_SVH
`define SIGNAL_PENDING_MASK_DISPATCHER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spmd assertion failed");
// next-cycle implication
`define SPMD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spmd assertion failed");
`else
`define SPMD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPMD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: design/spmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared widths, codes and helpers of the signal pending mask dispatcher.
// ----------------------------------------------------------------------------
package spmd_pkg;

  localparam int SigCount = 32;
  localparam int SigW     = 5;
  localparam int AddrW    = $clog2(SigCount);
  localparam int OpW      = 3;
  localparam int DispW    = 2;
  localparam int PidW     = 31;
  localparam int UidW     = 32;
  localparam int MaskW    = 32;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 2;
  localparam int SndW     = PidW + UidW;

  localparam logic [SigW:0] SigCountV = (SigW + 1)'(SigCount);

  typedef logic [SigCount-1:0] sig_vec_t;

  typedef enum logic [OpW-1:0] {
    OP_SEND     = 3'd0,
    OP_SET_ACT  = 3'd1,
    OP_SET_MASK = 3'd2,
    OP_GET_PEND = 3'd3,
    OP_EXEC_RST = 3'd4
  } op_e;

  typedef enum logic [DispW-1:0] {
    DISP_DEFAULT = 2'd0,
    DISP_IGNORE  = 2'd1,
    DISP_HANDLER = 2'd2,
    DISP_INVALID = 2'd3
  } disp_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KILL_MASK = 2'd0,
    CFG_KILL_NUM  = 2'd1,
    CFG_STOP_NUM  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SETTLE
  } state_e;

  // outcome of the settle pass
  typedef struct packed {
    sig_vec_t        pend;
    logic [SigW-1:0] kill;
    logic            handler;
  } settle_t;

  // index of the lowest set bit, zero when none
  function automatic logic [SigW-1:0] lowest_idx(input sig_vec_t v);
    logic [SigW-1:0] r;
    r = '0;
    for (int i = SigCount - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SigW'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/spmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmd request and response channels
// Valid/ready channels carrying one request item or one response item.
// ----------------------------------------------------------------------------
interface spmd_req_if;
  import spmd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       operation;
  logic [SigW-1:0]      signal_number;
  logic [PidW-1:0]      sender_pid;
  logic [UidW-1:0]      sender_uid;
  logic [DispW-1:0]     new_disposition;
  logic [MaskW-1:0]     new_mask;

  modport source (output valid, operation, signal_number, sender_pid, sender_uid,
                  new_disposition, new_mask, input ready);
  modport sink   (input valid, operation, signal_number, sender_pid, sender_uid,
                  new_disposition, new_mask, output ready);
endinterface

interface spmd_rsp_if;
  import spmd_pkg::*;
  logic            valid;
  logic            ready;
  logic            error;
  logic [SigW-1:0] info_signal;
  logic [PidW-1:0] info_pid;
  logic [UidW-1:0] info_uid;
  logic [SigW-1:0] kill_signal;
  logic            handler_needed;

  modport source (output valid, error, info_signal, info_pid, info_uid, kill_signal,
                  handler_needed, input ready);
  modport sink   (input valid, error, info_signal, info_pid, info_uid, kill_signal,
                  handler_needed, output ready);
endinterface

FILE: design/spmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmd_ram
// Single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module spmd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spmd_settle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmd_settle
// Clears deliverable default signals, picks the kill, flags handler work.
// ----------------------------------------------------------------------------
module spmd_settle (
  input  spmd_pkg::sig_vec_t pend_i,
  input  spmd_pkg::sig_vec_t mask_i,
  input  spmd_pkg::sig_vec_t ign_i,
  input  spmd_pkg::sig_vec_t hnd_i,
  input  spmd_pkg::sig_vec_t kill_class_i,
  output spmd_pkg::settle_t  res_o
);
  import spmd_pkg::*;

  sig_vec_t deliv;
  sig_vec_t dflt;

  assign deliv = pend_i & ~mask_i;
  assign dflt  = deliv & ~ign_i & ~hnd_i;

  always_comb begin
    res_o.pend    = pend_i & ~dflt;
    res_o.kill    = lowest_idx(dflt & kill_class_i);
    res_o.handler = |(deliv & hnd_i);
  end

endmodule

FILE: design/signal_pending_mask_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatcher
// Per-process signal controller: pending set, block mask, dispositions and
// sender records, one operation per request item, one response item each.
// ----------------------------------------------------------------------------
// Each request passes through idle, exec and settle while the response side
// keeps up. The idle cycle in which the item is accepted latches it. The exec
// cycle applies the operation and accesses the sender RAM (write on send,
// read of the popped entry on get pending). The settle cycle takes the RAM
// read data, runs the settle pass and loads the response register. The
// response becomes valid as the block returns to idle, and the next item can
// be accepted in that same cycle. The single RAM port and its registered read
// data place settle after exec. A new item is accepted as soon as the block is
// back in idle, even while the previous response still waits in the output
// register; the settle cycle holds while that register is full and not taken.
// Sender pid and uid live in the RAM without reset; only entries of pending
// signals are ever used, and send always writes them first. Pending set,
// block mask and dispositions (ignore and handler bit vectors) are flops.
// ----------------------------------------------------------------------------
`include "signal_pending_mask_dispatcher_macros.svh"

module signal_pending_mask_dispatcher (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  spmd_req_if.sink                   req_i,
  spmd_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [spmd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spmd_pkg::CfgW-1:0]  cfg_data_i
);
  import spmd_pkg::*;

  // configuration
  logic [CfgW-1:0] kdm_q;
  logic [SigW-1:0] kill_num_q, stop_num_q;

  // architectural state
  sig_vec_t pend_q, pend_d;
  sig_vec_t mask_q, mask_d;
  sig_vec_t ign_q, ign_d;
  sig_vec_t hnd_q, hnd_d;

  // latched request item
  logic [OpW-1:0]   op_q;
  logic [SigW-1:0]  num_q;
  logic [PidW-1:0]  pid_q;
  logic [UidW-1:0]  uid_q;
  logic [DispW-1:0] disp_q;
  logic [MaskW-1:0] nmask_q;

  // per-item results carried from exec to settle
  logic            err_q, err_d;
  logic [SigW-1:0] isig_q, isig_d;
  logic            found_q, found_d;

  // response register
  logic            out_valid_q, out_valid_d;
  logic            o_err_q;
  logic [SigW-1:0] o_isig_q;
  logic [PidW-1:0] o_pid_q;
  logic [UidW-1:0] o_uid_q;
  logic [SigW-1:0] o_kill_q;
  logic            o_hnd_q;

  state_e state_q, state_d;

  logic            req_fire;
  logic            out_load;
  logic            num_ok;
  logic            prot_num;
  sig_vec_t        num_bit;
  sig_vec_t        kill_bit, stop_bit;
  logic [SigW-1:0] lo_idx;
  sig_vec_t        lo_bit;
  sig_vec_t        deliv;

  logic             ram_en, ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [SndW-1:0]  ram_rdata;

  settle_t settle;

  // ---------------------------------------------------------------- handshake
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  // settle result may load only when the response slot is free or draining
  assign out_load    = (state_q == ST_SETTLE) && (!out_valid_q || rsp_o.ready);

  // ------------------------------------------------------------ state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_fire) state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_SETTLE;
      ST_SETTLE: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------ operation decoding
  assign num_ok   = (num_q != '0) && ({1'b0, num_q} < SigCountV);
  assign prot_num = (num_q == kill_num_q) || (num_q == stop_num_q);
  assign num_bit  = sig_vec_t'(1) << num_q;
  assign kill_bit = sig_vec_t'(1) << kill_num_q;
  assign stop_bit = sig_vec_t'(1) << stop_num_q;
  assign deliv    = pend_q & ~mask_q;
  assign lo_idx   = lowest_idx(deliv);
  assign lo_bit   = sig_vec_t'(1) << lo_idx;

  // sender RAM access happens only in the exec cycle; read data then holds
  always_comb begin
    ram_en   = (state_q == ST_EXEC);
    ram_we   = 1'b0;
    ram_addr = num_q[AddrW-1:0];
    if (op_q == OP_GET_PEND) begin
      ram_addr = lo_idx[AddrW-1:0];
    end
    if (op_q == OP_SEND && num_ok && ((ign_q | pend_q) & num_bit) == '0) begin
      ram_we = ram_en;
    end
  end

  // apply the operation in exec, the settle pass when the response loads
  always_comb begin
    pend_d  = pend_q;
    mask_d  = mask_q;
    ign_d   = ign_q;
    hnd_d   = hnd_q;
    err_d   = err_q;
    isig_d  = isig_q;
    found_d = found_q;
    if (state_q == ST_EXEC) begin
      err_d   = 1'b0;
      isig_d  = '0;
      found_d = 1'b0;
      unique case (op_e'(op_q))
        OP_SEND: begin
          if (!num_ok) begin
            err_d = 1'b1;
          end else if (((ign_q | pend_q) & num_bit) == '0) begin
            pend_d = pend_q | num_bit;
          end
        end
        OP_SET_ACT: begin
          if (!num_ok || disp_q == DISP_INVALID ||
              (disp_q != DISP_DEFAULT && prot_num)) begin
            err_d = 1'b1;
          end else begin
            ign_d = (disp_q == DISP_IGNORE)  ? (ign_q | num_bit) : (ign_q & ~num_bit);
            hnd_d = (disp_q == DISP_HANDLER) ? (hnd_q | num_bit) : (hnd_q & ~num_bit);
            if (disp_q == DISP_IGNORE) begin
              pend_d = pend_q & ~num_bit;
            end
          end
        end
        OP_SET_MASK: begin
          mask_d = nmask_q[SigCount-1:0] & ~kill_bit & ~stop_bit;
        end
        OP_GET_PEND: begin
          if (deliv != '0) begin
            isig_d  = lo_idx;
            found_d = 1'b1;
            pend_d  = pend_q & ~lo_bit;
          end
        end
        OP_EXEC_RST: begin
          hnd_d = '0;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end else if (out_load) begin
      pend_d = settle.pend;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      mask_q      <= '0;
      ign_q       <= '0;
      hnd_q       <= '0;
      out_valid_q <= 1'b0;
      kdm_q       <= 32'h0000_FFFE;
      kill_num_q  <= 5'd9;
      stop_num_q  <= 5'd19;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      mask_q      <= mask_d;
      ign_q       <= ign_d;
      hnd_q       <= hnd_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_KILL_MASK: kdm_q      <= cfg_data_i;
          CFG_KILL_NUM:  kill_num_q <= cfg_data_i[SigW-1:0];
          CFG_STOP_NUM:  stop_num_q <= cfg_data_i[SigW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: latch the item, carry per-item results, load response
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.operation;
      num_q   <= req_i.signal_number;
      pid_q   <= req_i.sender_pid;
      uid_q   <= req_i.sender_uid;
      disp_q  <= req_i.new_disposition;
      nmask_q <= req_i.new_mask;
    end
    err_q   <= err_d;
    isig_q  <= isig_d;
    found_q <= found_d;
    if (out_load) begin
      o_err_q  <= err_q;
      o_isig_q <= isig_q;
      o_pid_q  <= found_q ? ram_rdata[SndW-1:UidW] : '0;
      o_uid_q  <= found_q ? ram_rdata[UidW-1:0]    : '0;
      o_kill_q <= settle.kill;
      o_hnd_q  <= settle.handler;
    end
  end

  // ---------------------------------------------------------- sender records
  spmd_ram #(
    .Width (SndW),
    .Depth (SigCount)
  ) u_sender_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({pid_q, uid_q}),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------------------ settle pass
  spmd_settle u_settle (
    .pend_i       (pend_q),
    .mask_i       (mask_q),
    .ign_i        (ign_q),
    .hnd_i        (hnd_q),
    .kill_class_i (kdm_q[SigCount-1:0]),
    .res_o        (settle)
  );

  // ---------------------------------------------------------------- response
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.error          = o_err_q;
  assign rsp_o.info_signal    = o_isig_q;
  assign rsp_o.info_pid       = o_pid_q;
  assign rsp_o.info_uid       = o_uid_q;
  assign rsp_o.kill_signal    = o_kill_q;
  assign rsp_o.handler_needed = o_hnd_q;

  // -------------------------------------------------------------- assertions
  // an ignored signal is never left pending
  `SPMD_ASSERT_IMP(a_no_ignored_pending, clk_i, rst_ni, 1'b1, (pend_q & ign_q) == '0)
  // between items no deliverable signal with default disposition remains
  `SPMD_ASSERT_IMP(a_idle_settled, clk_i, rst_ni, state_q == ST_IDLE, (deliv & ~ign_q & ~hnd_q) == '0)
  // an accepted item goes straight to the exec cycle
  `SPMD_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, req_i.valid && req_i.ready, state_q == ST_EXEC)
  // a response appears only out of the settle cycle
  `SPMD_ASSERT_IMP(a_rsp_from_settle, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_SETTLE)

endmodule
